### rtl/ssim_pkg.sv
// Shared constants, types and helpers for the sorted set insert/member unit.
package ssim_pkg;

   localparam int CAPACITY = 128;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 8;
   localparam int REQ_W    = 40;   // mode + value, padded to bytes
   localparam int RSP_W    = 16;   // found, stored, full_res, entry_count, padded

   localparam logic MODE_QUERY  = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // What one cell hands to the next one up the row.
   typedef struct packed {
      logic                      valid;
      logic                      less;
      logic signed [VALUE_W-1:0] entry;
   } link_type;

   // Entry count as reported: saturates at the top of the 8-bit field.
   function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, cnt};
      if (wide > (CNT_W+COUNT_W)'(255)) begin
         return {COUNT_W{1'b1}};
      end
      return wide[COUNT_W-1:0];
   endfunction

endpackage

### rtl/sorted_set_insert_member_unit.sv
// Top level: sorted set of distinct signed 32-bit values with insert and membership.
//
// Usage
//   req_*  : one beat per operation. mode 0 asks whether value is in the set,
//            mode 1 inserts it. Accepted on tvalid && tready.
//   rsp_*  : exactly one beat per request, in request order: found, stored,
//            full_res and the entry count after the operation.
//   Storage is a row of CAPACITY cells kept in ascending order. At the accept
//   edge every cell compares its entry with the key in parallel; once the
//   output register is free, the row's match flags are ORed and, for an insert
//   of an absent value into a set that is not full, each cell either keeps its
//   entry, takes the key, or takes its lower neighbor. The response is
//   registered at the edge of that update. A new request is not taken until
//   the current one has committed its update.
//   A new request is taken while a finished response still waits in the
//   output register; if that register is still occupied when the next
//   update is due, the block holds req_tready low until rsp_tready frees it.
//   Reset (synchronous, active high) empties the set at once: valid bits
//   in every cell clear, no sweep needed. req_tready stays low during reset.
module sorted_set_insert_member_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ssim_pkg::REQ_W-1:0]    req_tdata,   // [0] mode, [32:1] value, rest zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ssim_pkg::RSP_W-1:0]    rsp_tdata    // [0] found, [1] stored, [2] full_res,
                                                      // [10:3] entry_count, rest zero
);
   import ssim_pkg::*;

   // request beat fields
   logic                      req_mode;
   logic signed [VALUE_W-1:0] req_value;
   assign req_mode  = req_tdata[0];
   assign req_value = req_tdata[VALUE_W:1];

   // control
   logic                      busy_ff, busy_in;
   logic                      mode_ff, mode_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   logic accept, out_free, commit, found, full, do_ins;

   // cell row
   link_type            link [CAPACITY+1];
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] valid_vec;

   assign req_tready = !busy_ff && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = busy_ff && out_free;
   assign found      = |eq_vec;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign do_ins     = commit && (mode_ff == MODE_INSERT) && !found && !full;

   // bottom of the row: "everything below is smaller", so cell 0 takes the key
   assign link[0] = '{valid: 1'b1, less: 1'b1, entry: value_ff};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ssim_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmp_en    (accept),
         .cmp_value (req_value),
         .ins_en    (do_ins),
         .ins_value (value_ff),
         .prev      (link[i]),
         .link      (link[i+1]),
         .equal     (eq_vec[i])
      );
      assign valid_vec[i] = link[i+1].valid;
   end

   always_comb begin
      busy_in      = busy_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         busy_in  = 1'b1;
         mode_in  = req_mode;
         value_in = req_value;
      end

      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (commit) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[0]   = found;
         rsp_data_in[1]   = do_ins;
         rsp_data_in[2]   = (mode_ff == MODE_INSERT) && !found && full;
         rsp_data_in[10:3] = sat_count(count_in);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // occupied cells always form a prefix whose length is the count
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid bits disagree with entry count");

   // the count only moves by one, and only on a committed insert
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("entry count did not advance on insert");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !do_ins |=> count_ff == $past(count_ff))
      else $error("entry count changed without insert");

   // a stored value was never already present, and the stored/refused flags exclude
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1] |-> !rsp_data_ff[0] && !rsp_data_ff[2])
      else $error("inconsistent response flags");

endmodule

### rtl/ssim_cell.sv
// One storage cell of the sorted row: compare against the key, take insert or shift.
module ssim_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmp_en,    // key beat accepted
   input  logic signed [ssim_pkg::VALUE_W-1:0] cmp_value,
   input  logic                               ins_en,    // commit an insert
   input  logic signed [ssim_pkg::VALUE_W-1:0] ins_value,
   input  ssim_pkg::link_type                 prev,      // from the cell below
   output ssim_pkg::link_type                 link,      // to the cell above
   output logic                               equal
);
   import ssim_pkg::*;

   logic                      valid_ff, valid_in;
   logic                      less_ff,  less_in;
   logic                      eq_ff,    eq_in;
   logic signed [VALUE_W-1:0] entry_ff, entry_in;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      less_in  = less_ff;
      eq_in    = eq_ff;
      if (cmp_en) begin
         less_in = valid_ff && (entry_ff < cmp_value);
         eq_in   = valid_ff && (entry_ff == cmp_value);
      end
      if (ins_en && !less_ff) begin
         // slot of the new key if the cell below is smaller, else shift up
         valid_in = prev.valid;
         entry_in = prev.less ? ins_value : prev.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         less_ff  <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         less_ff  <= less_in;
         eq_ff    <= eq_in;
      end
      entry_ff <= entry_in;
   end

   assign link  = '{valid: valid_ff, less: less_ff, entry: entry_ff};
   assign equal = eq_ff;

endmodule

### bench/sorted_set_insert_member_unit_test.sv
// Self-checking testbench for the sorted set insert/membership unit.
`timescale 1ns / 1ps

module sorted_set_insert_member_unit_test;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int RANDOM_BEATS = 1800;
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the pipe

   // One response beat, decoded into its fields.
   typedef struct packed {
      logic       found;
      logic       stored;
      logic       full_res;
      logic [7:0] entry_count;
   } set_response_type;

   // Tracks the set contents and the responses still owed by the block.
   class sorted_set_tracker;
      logic signed [31:0] members[$];     // ascending, distinct
      set_response_type   awaited[$];     // oldest first
      int mismatches = 0;
      int checked    = 0;
      int refused    = 0;
      int requests   = 0;

      // Apply one accepted request and queue the response it must produce.
      function void note_request(input logic mode, input logic signed [31:0] value);
         int pos;
         int cnt;
         set_response_type want;
         pos = 0;
         while (pos < members.size() && members[pos] < value) pos++;
         want = '0;
         want.found = (pos < members.size()) && (members[pos] == value);
         if (mode == ssim_pkg::MODE_INSERT && !want.found) begin
            if (members.size() >= ssim_pkg::CAPACITY) begin
               want.full_res = 1'b1;
               refused++;
            end else begin
               members.insert(pos, value);
               want.stored = 1'b1;
            end
         end
         cnt = (members.size() > 255) ? 255 : members.size();
         want.entry_count = cnt[7:0];
         awaited.push_back(want);
         requests++;
      endfunction

      // Compare one accepted response beat with the oldest awaited one.
      function void check_response(input logic [ssim_pkg::RSP_W-1:0] data);
         set_response_type got;
         set_response_type want;
         got.found       = data[0];
         got.stored      = data[1];
         got.full_res    = data[2];
         got.entry_count = data[10:3];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] stray response: found=%b stored=%b full=%b count=%0d",
                        $realtime, got.found, got.stored, got.full_res, got.entry_count);
         end else begin
            want = awaited.pop_front();
            checked++;
            if (got.found !== want.found || got.stored !== want.stored ||
                got.full_res !== want.full_res || got.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] response %0d: want found=%b stored=%b full=%b count=%0d",
                           $realtime, checked, want.found, want.stored, want.full_res,
                           want.entry_count);
                  $display("        got  found=%b stored=%b full=%b count=%0d",
                           got.found, got.stored, got.full_res, got.entry_count);
               end
            end
         end
      endfunction
   endclass

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [ssim_pkg::REQ_W-1:0] req_tdata  = '0;   // [0] mode, [32:1] value, rest zero
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [ssim_pkg::RSP_W-1:0] rsp_tdata;          // [0] found, [1] stored, [2] full_res,
                                                   // [10:3] entry_count, rest zero

   sorted_set_tracker tracker = new();

   bit quiet_stretch = 1'b0;   // both sides stop idling while set
   bit hold_request  = 1'b0;   // one-shot trigger for the long receiver hold-off

   sorted_set_insert_member_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block wedges. Normal runs take a small fraction of this.
   initial begin
      #2_000_000;
      $display("sorted_set_insert_member_unit_test failed");
      $finish;
   end

   // Offer one request beat and return right after the edge that accepts it.
   // Valid is lowered only when an idle gap is taken, so a back-to-back beat
   // never sees a low and a high written in the same step.
   task automatic send_beat(input logic mode, input logic signed [31:0] value);
      if (!quiet_stretch && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 31) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ssim_pkg::REQ_W'({value, mode});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(mode, value);
   endtask

   // Mix of values: members already held (hits), their neighbors (ordering
   // at close range), the extremes of the signed range, and fully random ones.
   function automatic logic signed [31:0] pick_value();
      int roll;
      int n;
      logic signed [31:0] v;
      roll = $urandom_range(99);
      n    = tracker.members.size();
      if (roll < 40 && n > 0) begin
         v = tracker.members[$urandom_range(n - 1)];
      end else if (roll < 55 && n > 0) begin
         v = tracker.members[$urandom_range(n - 1)];
         v = ($urandom_range(1) == 1) ? v + 32'sd1 : v - 32'sd1;
      end else if (roll < 70) begin
         case ($urandom_range(6))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = VAL_MIN + 32'sd1;
            3: v = VAL_MAX - 32'sd1;
            4: v = -32'sd1;
            5: v = 32'sd1;
            default: v = 32'sd0;
         endcase
      end else begin
         v = $urandom();
      end
      return v;
   endfunction

   // Receiver: samples the response beat at each edge, then decides tready.
   // The long hold-off is counted here so the sender keeps pushing meanwhile.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            tracker.check_response(rsp_tdata);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 31);
         end
      end
   end

   initial begin
      int i;
      int k;
      logic signed [31:0] gap_value;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-set query, extremes, duplicate inserts, hits and
      // near misses around stored values.
      send_beat(ssim_pkg::MODE_QUERY,  VAL_MIN);
      send_beat(ssim_pkg::MODE_INSERT, VAL_MIN);
      send_beat(ssim_pkg::MODE_INSERT, VAL_MAX);
      send_beat(ssim_pkg::MODE_INSERT, 32'sd0);
      send_beat(ssim_pkg::MODE_INSERT, -32'sd1);
      send_beat(ssim_pkg::MODE_INSERT, 32'sd1);
      send_beat(ssim_pkg::MODE_INSERT, VAL_MAX);      // already present
      send_beat(ssim_pkg::MODE_INSERT, VAL_MIN);      // already present
      send_beat(ssim_pkg::MODE_QUERY,  VAL_MIN);
      send_beat(ssim_pkg::MODE_QUERY,  VAL_MAX);
      send_beat(ssim_pkg::MODE_QUERY,  32'sd0);
      send_beat(ssim_pkg::MODE_QUERY,  -32'sd1);
      send_beat(ssim_pkg::MODE_QUERY,  32'sd2);       // absent
      send_beat(ssim_pkg::MODE_QUERY,  VAL_MAX - 32'sd1);
      send_beat(ssim_pkg::MODE_QUERY,  VAL_MIN + 32'sd1);
      send_beat(ssim_pkg::MODE_INSERT, VAL_MIN + 32'sd1);
      send_beat(ssim_pkg::MODE_INSERT, VAL_MAX - 32'sd1);
      send_beat(ssim_pkg::MODE_INSERT, 32'sh4000_0000);
      send_beat(ssim_pkg::MODE_INSERT, 32'shc000_0000);
      send_beat(ssim_pkg::MODE_QUERY,  32'sh4000_0000);
      send_beat(ssim_pkg::MODE_QUERY,  32'shc000_0001);

      // Random: the set only grows (no delete, one reset), so at this insert
      // rate it fills around mid-run and the rest exercises the full store.
      for (i = 0; i < RANDOM_BEATS; i++) begin
         quiet_stretch = (i >= 900 && i < 1150);
         if (i == 300) hold_request = 1'b1;
         send_beat(($urandom_range(99) < 35) ? ssim_pkg::MODE_INSERT : ssim_pkg::MODE_QUERY,
                   pick_value());
      end
      quiet_stretch = 1'b0;

      // Make sure the store is full, then hit it with refused and found inserts.
      while (tracker.members.size() < ssim_pkg::CAPACITY)
         send_beat(ssim_pkg::MODE_INSERT, $urandom());
      k = 0;
      while (tracker.members[k + 1] == tracker.members[k] + 32'sd1) k++;
      gap_value = tracker.members[k] + 32'sd1;
      send_beat(ssim_pkg::MODE_INSERT, gap_value);                  // refused: full
      send_beat(ssim_pkg::MODE_INSERT, tracker.members[0]);         // present
      send_beat(ssim_pkg::MODE_INSERT, tracker.members[ssim_pkg::CAPACITY - 1]);
      send_beat(ssim_pkg::MODE_QUERY,  gap_value);
      req_tvalid <= 1'b0;

      // Drain, then idle on to catch any stray response beat.
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d request beats, %0d responses checked, %0d refused inserts,",
               tracker.requests, tracker.checked, tracker.refused);
      $display("the set reaching %0d of %0d entries; %0d mismatches.",
               tracker.members.size(), ssim_pkg::CAPACITY, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("sorted_set_insert_member_unit_test passed");
      end else begin
         $display("sorted_set_insert_member_unit_test failed");
      end
      $finish;
   end

endmodule
